/* sv/assert_macros.svh */
// assertion helpers, clocked on the rising edge, quiet while reset is held
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/rthm_pkg.sv */
package rthm_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;

    localparam logic [2:0] REG_ACCEPT_TH  = 3'd0;
    localparam logic [2:0] REG_DEGRADE_TH = 3'd1;
    localparam logic [2:0] REG_MIN_CONS   = 3'd2;
    localparam logic [2:0] REG_MAX_HOLD   = 3'd3;
    localparam logic [2:0] REG_SIGMA_MAX  = 3'd4;
    localparam logic [2:0] REG_SPAN_MAX   = 3'd5;

    localparam logic [12:0] RST_ACCEPT_TH  = 13'd2253;
    localparam logic [12:0] RST_DEGRADE_TH = 13'd1229;
    localparam logic [12:0] RST_MIN_CONS   = 13'd2048;
    localparam logic [7:0]  RST_MAX_HOLD   = 8'd10;
    localparam logic [11:0] RST_SIGMA_MAX  = 12'd240;
    localparam logic [11:0] RST_SPAN_MAX   = 12'd320;

    localparam logic [1:0] DEC_ACCEPT   = 2'd0;
    localparam logic [1:0] DEC_HOLD     = 2'd1;
    localparam logic [1:0] DEC_DEGRADED = 2'd2;
    localparam logic [1:0] DEC_ABSTAIN  = 2'd3;

    localparam logic [2:0] RSN_ACCEPT    = 3'd0;
    localparam logic [2:0] RSN_HOLD_VOL  = 3'd1;
    localparam logic [2:0] RSN_HOLD_LOW  = 3'd2;
    localparam logic [2:0] RSN_DEGRADED  = 3'd3;
    localparam logic [2:0] RSN_ABSTAIN   = 3'd4;

    localparam logic [12:0] ONE_Q12 = 13'd4096;
    localparam logic [18:0] RES_NUM = 19'd262144;

    typedef struct packed {
        logic start;
        logic sqrt;
    } t_unit_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

/* sv/rate_trust_hold_machine.sv */
// channel   direction  handshake             payload
// input     in         i_valid / o_ready     i_raw_rate .. i_bin_resolution
// result    out        o_valid / i_ready     o_decision .. o_trust_age_out
// config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// a request passes steps for idle, agreement, resolution, the products and the decision,
// a sqrt, and the span and bin divides when used; a nonzero rate with two or more
// stored rates adds a walk over the stored rates, 2 steps, two divides and a
// sqrt; all divides and square roots run on the shared divide/sqrt unit
// synchronous active-low reset clears control, trust state and configuration registers
// the result stays in the output register until taken; the next request is
// taken meanwhile and waits only at the final decision step
module rate_trust_hold_machine #(
    parameter int WINDOW_DEPTH = rthm_pkg::WINDOW_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_raw_rate,
    input  logic [12:0] i_raw_confidence,
    input  logic [11:0] i_top_min_rate,
    input  logic [11:0] i_top_max_rate,
    input  logic [5:0]  i_top_count,
    input  logic [13:0] i_bin_resolution,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_decision,
    output logic [2:0]  o_reason,
    output logic [11:0] o_out_rate,
    output logic        o_out_valid,
    output logic [12:0] o_calibrated_confidence,
    output logic [12:0] o_consistency,
    output logic [12:0] o_agreement,
    output logic [12:0] o_resolution_quality,
    output logic [11:0] o_trusted_rate_out,
    output logic [15:0] o_trust_age_out
);
    import rthm_pkg::*;

    localparam int NW    = $clog2(WINDOW_DEPTH + 2);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int S_W   = 12 + NW;
    localparam int Q_W   = 24 + NW;
    localparam int NQ_W  = Q_W + NW;
    localparam int NUM_R = (NQ_W + 8 > 24) ? NQ_W + 8 : 24;
    localparam int NUM_W = NUM_R + (NUM_R % 2);
    localparam int DEN_W = (2 * NW > 14) ? 2 * NW : 14;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_WALK = 4'd1;
    localparam logic [3:0] ST_MNQ  = 4'd2;
    localparam logic [3:0] ST_MSS  = 4'd3;
    localparam logic [3:0] ST_DIV1 = 4'd4;
    localparam logic [3:0] ST_SQ1  = 4'd5;
    localparam logic [3:0] ST_DIV2 = 4'd6;
    localparam logic [3:0] ST_AGR  = 4'd7;
    localparam logic [3:0] ST_DIV3 = 4'd8;
    localparam logic [3:0] ST_RES  = 4'd9;
    localparam logic [3:0] ST_DIV4 = 4'd10;
    localparam logic [3:0] ST_MCA  = 4'd11;
    localparam logic [3:0] ST_SQ2  = 4'd12;
    localparam logic [3:0] ST_MC1  = 4'd13;
    localparam logic [3:0] ST_MC2  = 4'd14;
    localparam logic [3:0] ST_DEC  = 4'd15;

    // configuration
    logic [12:0] r_acc_th, r_deg_th, r_min_cons;
    logic [7:0]  r_max_hold;
    logic [11:0] r_sigma_max, r_span_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_th    <= RST_ACCEPT_TH;
            r_deg_th    <= RST_DEGRADE_TH;
            r_min_cons  <= RST_MIN_CONS;
            r_max_hold  <= RST_MAX_HOLD;
            r_sigma_max <= RST_SIGMA_MAX;
            r_span_max  <= RST_SPAN_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ACCEPT_TH:  r_acc_th    <= i_cfg_data;
                REG_DEGRADE_TH: r_deg_th    <= i_cfg_data;
                REG_MIN_CONS:   r_min_cons  <= i_cfg_data;
                REG_MAX_HOLD:   r_max_hold  <= i_cfg_data[7:0];
                REG_SIGMA_MAX:  r_sigma_max <= i_cfg_data[11:0];
                REG_SPAN_MAX:   r_span_max  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // control and trust state
    logic [3:0]    r_state;
    logic          r_go, r_rd_vld;
    logic [CW-1:0] r_count, r_idx;
    logic [AW-1:0] r_head;
    logic [11:0]   r_trusted;
    logic [15:0]   r_age;
    logic          r_out_vld;

    // request fields and working values
    logic [11:0]     r_rate, r_tmin, r_tmax;
    logic [12:0]     r_rawc;
    logic [5:0]      r_tcnt;
    logic [13:0]     r_bin;
    logic [S_W-1:0]  r_s;
    logic [Q_W-1:0]  r_qs;
    logic [NQ_W-1:0] r_nq;
    logic [2*S_W-1:0] r_ss;
    logic [DEN_W-1:0] r_nn;
    logic [11:0]     r_rd_data;
    logic [12:0]     r_cons, r_agr, r_res, r_sq;
    logic [24:0]     r_ca;
    logic [25:0]     r_p1;
    logic [38:0]     r_p2;

    logic [11:0] r_mem [WINDOW_DEPTH];

    // shared divide / square-root unit
    t_unit_req        w_req;
    t_unit_stat       w_stat;
    logic [NUM_W-1:0] w_num, w_q;
    logic [DEN_W-1:0] w_den;

    rthm_unit #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_num    (w_num),
        .i_den    (w_den),
        .o_stat   (w_stat),
        .o_result (w_q)
    );

    logic [NW-1:0]   w_n;
    logic [NQ_W-1:0] w_d;
    logic [11:0]     w_span, w_sm, w_spm;
    logic [14:0]     w_cal_raw;
    logic [12:0]     w_cal;
    logic [15:0]     w_age_inc;
    logic            w_accept, w_hold, w_degr, w_fire;
    logic            n_go;

    always_comb begin
        w_n    = NW'(r_count) + NW'(1);
        w_d    = r_nq - NQ_W'(r_ss);
        w_span = (r_tmax >= r_tmin) ? r_tmax - r_tmin : r_tmin - r_tmax;
        w_sm   = (r_sigma_max == 12'd0) ? 12'd1 : r_sigma_max;
        w_spm  = (r_span_max == 12'd0) ? 12'd1 : r_span_max;

        w_req.start = r_go;
        w_req.sqrt  = (r_state == ST_SQ1) || (r_state == ST_SQ2);
        w_num = '0;
        w_den = DEN_W'(1);
        case (r_state)
            ST_DIV1: begin
                w_num = NUM_W'(w_d) << 8;
                w_den = r_nn;
            end
            ST_SQ1:  w_num = w_q;
            ST_DIV2: begin
                w_num = w_q << 8;
                w_den = DEN_W'(w_sm);
            end
            ST_DIV3: begin
                w_num = NUM_W'(w_span) << 12;
                w_den = DEN_W'(w_spm);
            end
            ST_DIV4: begin
                w_num = NUM_W'(RES_NUM);
                w_den = DEN_W'(r_bin);
            end
            ST_SQ2:  w_num = NUM_W'(r_ca);
            default: ;
        endcase

        n_go = 1'b0;
        case (r_state)
            ST_MSS, ST_MCA:   n_go = 1'b1;
            ST_DIV1, ST_SQ1:  n_go = w_stat.done;
            ST_AGR:           n_go = (r_tcnt >= 6'd2);
            ST_RES:           n_go = (r_bin != 14'd0);
            default: ;
        endcase

        w_cal_raw = r_p2[38:24];
        w_cal     = (w_cal_raw > 15'(ONE_Q12)) ? ONE_Q12 : w_cal_raw[12:0];
        w_age_inc = (r_age == 16'hFFFF) ? r_age : r_age + 16'd1;
        w_accept  = (w_cal >= r_acc_th) && (r_cons >= r_min_cons);
        w_hold    = (r_trusted != 12'd0) && (w_age_inc < {8'd0, r_max_hold});
        w_degr    = (w_cal >= r_deg_th);
        w_fire    = (r_state == ST_DEC) && (!r_out_vld || i_ready);
    end

    // window memory
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_idx[AW-1:0]];
        if (w_fire && r_rate != 12'd0) begin
            r_mem[r_head] <= r_rate;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_go      <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_count   <= '0;
            r_head    <= '0;
            r_trusted <= 12'd0;
            r_age     <= 16'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_go      <= n_go;
            r_out_vld <= w_fire || (r_out_vld && !i_ready);
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_idx    <= '0;
                        r_rd_vld <= 1'b0;
                        if (i_raw_rate == 12'd0) begin
                            r_cons  <= 13'd0;
                            r_state <= ST_AGR;
                        end else if (r_count < CW'(2)) begin
                            r_cons  <= ONE_Q12;
                            r_state <= ST_AGR;
                        end else begin
                            r_state <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (r_idx < r_count) begin
                        r_rd_vld <= 1'b1;
                        r_idx    <= r_idx + CW'(1);
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= ST_MNQ;
                        end
                    end
                end
                ST_MNQ: r_state <= ST_MSS;
                ST_MSS: r_state <= ST_DIV1;
                ST_DIV1: begin
                    if (w_stat.done) begin
                        r_state <= ST_SQ1;
                    end
                end
                ST_SQ1: begin
                    if (w_stat.done) begin
                        r_state <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (w_stat.done) begin
                        r_cons  <= (w_q >= NUM_W'(ONE_Q12)) ? 13'd0 : ONE_Q12 - w_q[12:0];
                        r_state <= ST_AGR;
                    end
                end
                ST_AGR: begin
                    if (r_tcnt >= 6'd2) begin
                        r_state <= ST_DIV3;
                    end else begin
                        r_agr   <= ONE_Q12;
                        r_state <= ST_RES;
                    end
                end
                ST_DIV3: begin
                    if (w_stat.done) begin
                        r_agr   <= (w_q >= NUM_W'(ONE_Q12)) ? 13'd0 : ONE_Q12 - w_q[12:0];
                        r_state <= ST_RES;
                    end
                end
                ST_RES: begin
                    if (r_bin != 14'd0) begin
                        r_state <= ST_DIV4;
                    end else begin
                        r_res   <= ONE_Q12;
                        r_state <= ST_MCA;
                    end
                end
                ST_DIV4: begin
                    if (w_stat.done) begin
                        r_res   <= (w_q > NUM_W'(ONE_Q12)) ? ONE_Q12 : w_q[12:0];
                        r_state <= ST_MCA;
                    end
                end
                ST_MCA: r_state <= ST_SQ2;
                ST_SQ2: begin
                    if (w_stat.done) begin
                        r_state <= ST_MC1;
                    end
                end
                ST_MC1: r_state <= ST_MC2;
                ST_MC2: r_state <= ST_DEC;
                ST_DEC: begin
                    if (w_fire) begin
                        r_state <= ST_IDLE;
                        if (w_accept) begin
                            r_trusted <= r_rate;
                            r_age     <= 16'd0;
                        end else begin
                            r_age <= w_age_inc;
                        end
                        if (r_rate != 12'd0) begin
                            r_head <= (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + AW'(1);
                            if (r_count < CW'(WINDOW_DEPTH)) begin
                                r_count <= r_count + CW'(1);
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_rate <= i_raw_rate;
            r_rawc <= i_raw_confidence;
            r_tmin <= i_top_min_rate;
            r_tmax <= i_top_max_rate;
            r_tcnt <= i_top_count;
            r_bin  <= i_bin_resolution;
            r_s    <= S_W'(i_raw_rate);
            r_qs   <= Q_W'(i_raw_rate) * Q_W'(i_raw_rate);
        end else if (r_state == ST_WALK && r_rd_vld) begin
            r_s  <= r_s + S_W'(r_rd_data);
            r_qs <= r_qs + Q_W'(r_rd_data) * Q_W'(r_rd_data);
        end
        if (r_state == ST_MNQ) begin
            r_nq <= NQ_W'(w_n) * NQ_W'(r_qs);
            r_nn <= DEN_W'(w_n) * DEN_W'(w_n);
        end
        if (r_state == ST_MSS) begin
            r_ss <= (2*S_W)'(r_s) * (2*S_W)'(r_s);
        end
        if (r_state == ST_MCA) begin
            r_ca <= 25'(r_cons) * 25'(r_agr);
        end
        if (r_state == ST_SQ2 && w_stat.done) begin
            r_sq <= w_q[12:0];
        end
        if (r_state == ST_MC1) begin
            r_p1 <= 26'(r_rawc) * 26'(r_sq);
        end
        if (r_state == ST_MC2) begin
            r_p2 <= 39'(r_p1) * 39'(r_res);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_calibrated_confidence <= w_cal;
            o_consistency           <= r_cons;
            o_agreement             <= r_agr;
            o_resolution_quality    <= r_res;
            o_trusted_rate_out      <= w_accept ? r_rate : r_trusted;
            o_trust_age_out         <= w_accept ? 16'd0 : w_age_inc;
            if (w_accept) begin
                o_decision  <= DEC_ACCEPT;
                o_reason    <= RSN_ACCEPT;
                o_out_rate  <= r_rate;
                o_out_valid <= 1'b1;
            end else if (w_hold) begin
                o_decision  <= DEC_HOLD;
                o_reason    <= (r_cons < r_min_cons) ? RSN_HOLD_VOL : RSN_HOLD_LOW;
                o_out_rate  <= r_trusted;
                o_out_valid <= 1'b1;
            end else if (w_degr) begin
                o_decision  <= DEC_DEGRADED;
                o_reason    <= RSN_DEGRADED;
                o_out_rate  <= r_rate;
                o_out_valid <= 1'b1;
            end else begin
                o_decision  <= DEC_ABSTAIN;
                o_reason    <= RSN_ABSTAIN;
                o_out_rate  <= 12'd0;
                o_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_vld;

    `include "assert_macros.svh"

    `ASSERT_IMPLY(a_idle_unit_quiet, i_clk, i_rst_n, o_ready, !w_stat.busy)
    `ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `ASSERT_IMPLY(a_abstain_no_rate, i_clk, i_rst_n, o_valid && o_decision == DEC_ABSTAIN, !o_out_valid && o_out_rate == 12'd0)
    `ASSERT_IMPLY(a_fill_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(WINDOW_DEPTH))

endmodule

/* sv/rthm_unit.sv */
module rthm_unit #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rthm_pkg::t_unit_req   i_req,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    output rthm_pkg::t_unit_stat  o_stat,
    output logic [NUM_W-1:0]      o_result
);
    import rthm_pkg::*;

    localparam int R_W = (DEN_W + 1 > NUM_W / 2 + 3) ? DEN_W + 1 : NUM_W / 2 + 3;
    localparam int C_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_x, r_q;
    logic [R_W-1:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic             r_sqrt, r_busy, r_done;
    logic [C_W-1:0]   r_cnt;

    logic [R_W-1:0] d_sh, s_sh, s_trial, sh, sub, n_rem;
    logic           take;

    always_comb begin
        d_sh    = {r_rem[R_W-2:0], r_x[NUM_W-1]};
        s_sh    = {r_rem[R_W-3:0], r_x[NUM_W-1 -: 2]};
        s_trial = {r_q[R_W-3:0], 2'b01};
        sh      = r_sqrt ? s_sh : d_sh;
        sub     = r_sqrt ? s_trial : {{(R_W-DEN_W){1'b0}}, r_den};
        take    = (sh >= sub);
        n_rem   = take ? sh - sub : sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x    <= i_num;
            r_q    <= '0;
            r_rem  <= '0;
            r_den  <= i_den;
            r_sqrt <= i_req.sqrt;
            r_cnt  <= i_req.sqrt ? C_W'(NUM_W / 2 - 1) : C_W'(NUM_W - 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[NUM_W-2:0], take};
            r_x   <= r_sqrt ? (r_x << 2) : (r_x << 1);
            r_cnt <= r_cnt - C_W'(1);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_q;

endmodule

/* tb/rate_trust_hold_machine_tb.sv */
`timescale 1ns / 100ps

module rate_trust_hold_machine_tb;
    import rthm_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;
    localparam logic [2:0] REG_NONE_LO = 3'd6;
    localparam logic [2:0] REG_NONE_HI = 3'd7;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 400;
    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [11:0] raw_rate;
        logic [12:0] raw_confidence;
        logic [11:0] top_min_rate;
        logic [11:0] top_max_rate;
        logic [5:0]  top_count;
        logic [13:0] bin_resolution;
    } t_rate_req;

    typedef struct packed {
        logic [1:0]  decision;
        logic [2:0]  reason;
        logic [11:0] out_rate;
        logic        out_valid;
        logic [12:0] calib;
        logic [12:0] consistency;
        logic [12:0] agreement;
        logic [12:0] res_quality;
        logic [11:0] trusted_rate;
        logic [15:0] age_out;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [12:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [11:0] i_raw_rate = '0;
    logic [12:0] i_raw_confidence = '0;
    logic [11:0] i_top_min_rate = '0;
    logic [11:0] i_top_max_rate = '0;
    logic [5:0]  i_top_count = '0;
    logic [13:0] i_bin_resolution = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_decision;
    logic [2:0]  o_reason;
    logic [11:0] o_out_rate;
    logic        o_out_valid;
    logic [12:0] o_calibrated_confidence;
    logic [12:0] o_consistency;
    logic [12:0] o_agreement;
    logic [12:0] o_resolution_quality;
    logic [11:0] o_trusted_rate_out;
    logic [15:0] o_trust_age_out;

    rate_trust_hold_machine i_dut (.*);

    // shadow registers and trust state
    logic [12:0] cfg_accept_th, cfg_degrade_th, cfg_min_cons;
    logic [7:0]  cfg_max_hold;
    logic [11:0] cfg_sigma_max, cfg_span_max;
    logic [11:0] hist_rates [DEPTH];
    int          hist_cnt, hist_head;
    logic [11:0] trust_rate;
    logic [15:0] exp_age;

    // expected results in request order
    t_verdict exp_mem [EXP_DEPTH];
    int  exp_wr = 0;
    int  exp_rd = 0;
    int  fail_cnt = 0;
    bit  quiet_mode = 1'b0;
    int  hold_req_cnt = 0;
    int  hold_seen_cnt = 0;
    int  hold_left = 0;
    int  stall_cnt = 0;

    initial forever #6 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root, rem, trial;
        root = 0;
        rem = 0;
        for (int i = 31; i >= 0; i--) begin
            rem = (rem << 2) | ((x >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 64'd1;
            end
        end
        return root;
    endfunction

    function automatic t_verdict judge_rate(input t_rate_req r);
        t_verdict v;
        longint unsigned n, s, q, d, sd4, dv, div, span, sq, cal, rate;
        int unsigned cons, agr, res;
        rate = r.raw_rate;
        if (rate == 0) begin
            cons = 0;
        end else if (hist_cnt + 1 < 3) begin
            cons = 4096;
        end else begin
            n = hist_cnt + 1;
            s = rate;
            q = rate * rate;
            for (int i = 0; i < hist_cnt; i++) begin
                s += hist_rates[i];
                q += longint'(hist_rates[i]) * hist_rates[i];
            end
            d = n * q - s * s;
            sd4 = int_sqrt((256 * d) / (n * n));
            div = (cfg_sigma_max == 0) ? 1 : cfg_sigma_max;
            dv = (256 * sd4) / div;
            cons = (dv >= 4096) ? 0 : 32'(4096 - dv);
        end
        agr = 4096;
        if (r.top_count >= 2) begin
            span = (r.top_max_rate >= r.top_min_rate) ? r.top_max_rate - r.top_min_rate
                                                      : r.top_min_rate - r.top_max_rate;
            div = (cfg_span_max == 0) ? 1 : cfg_span_max;
            dv = (4096 * span) / div;
            agr = (dv >= 4096) ? 0 : 32'(4096 - dv);
        end
        res = 4096;
        if (r.bin_resolution != 0) begin
            res = 262144 / r.bin_resolution;
            if (res > 4096) res = 4096;
        end
        sq = int_sqrt(longint'(cons) * agr);
        cal = (longint'(r.raw_confidence) * sq * res) >> 24;
        if (cal > 4096) cal = 4096;
        if (exp_age != 16'hFFFF) exp_age = exp_age + 16'd1;
        if (cal >= cfg_accept_th && cons >= cfg_min_cons) begin
            v.decision = DEC_ACCEPT;
            v.reason = RSN_ACCEPT;
            v.out_rate = r.raw_rate;
            trust_rate = r.raw_rate;
            exp_age = 16'd0;
        end else if (trust_rate != 0 && exp_age < cfg_max_hold) begin
            v.decision = DEC_HOLD;
            v.reason = (cons < cfg_min_cons) ? RSN_HOLD_VOL : RSN_HOLD_LOW;
            v.out_rate = trust_rate;
        end else if (cal >= cfg_degrade_th) begin
            v.decision = DEC_DEGRADED;
            v.reason = RSN_DEGRADED;
            v.out_rate = r.raw_rate;
        end else begin
            v.decision = DEC_ABSTAIN;
            v.reason = RSN_ABSTAIN;
            v.out_rate = '0;
        end
        v.out_valid = (v.decision != DEC_ABSTAIN);
        v.calib = cal[12:0];
        v.consistency = cons[12:0];
        v.agreement = agr[12:0];
        v.res_quality = res[12:0];
        if (r.raw_rate != 0) begin
            hist_rates[hist_head] = r.raw_rate;
            hist_head = (hist_head + 1 >= DEPTH) ? 0 : hist_head + 1;
            if (hist_cnt < DEPTH) hist_cnt++;
        end
        v.trusted_rate = trust_rate;
        v.age_out = exp_age;
        return v;
    endfunction

    task automatic idle_gap();
        while (!quiet_mode && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_rate(input t_rate_req r);
        idle_gap();
        i_valid <= 1'b1;
        {i_raw_rate, i_raw_confidence, i_top_min_rate, i_top_max_rate,
         i_top_count, i_bin_resolution} <= r;
        do @(posedge i_clk); while (!o_ready);
        exp_mem[exp_wr % EXP_DEPTH] = judge_rate(r);
        exp_wr++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (exp_wr != exp_rd) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_ACCEPT_TH:  cfg_accept_th = data;
            REG_DEGRADE_TH: cfg_degrade_th = data;
            REG_MIN_CONS:   cfg_min_cons = data;
            REG_MAX_HOLD:   cfg_max_hold = data[7:0];
            REG_SIGMA_MAX:  cfg_sigma_max = data[11:0];
            REG_SPAN_MAX:   cfg_span_max = data[11:0];
            default: ;
        endcase
    endtask

    function automatic t_rate_req make_rate(input int base);
        t_rate_req r;
        int rate;
        if ($urandom_range(99) < 80) begin
            rate = base + int'($urandom_range(24)) - 12;
            if (rate < 1) rate = 1;
            if (rate > 4095) rate = 4095;
            r.raw_rate = 12'(rate);
            if ($urandom_range(19) == 0) r.raw_rate = '0;
            r.raw_confidence = $urandom_range(9) < 8 ? 13'($urandom_range(4096, 2000))
                                                     : 13'($urandom_range(4096));
            r.top_min_rate = r.raw_rate - 12'($urandom_range(40));
            r.top_max_rate = r.raw_rate + 12'($urandom_range(40));
            r.top_count = 6'($urandom_range(6));
            r.bin_resolution = 14'($urandom_range(120));
        end else begin
            r = t_rate_req'({$urandom, $urandom, $urandom});
        end
        return r;
    endfunction

    task automatic run_stream(input int count);
        int base;
        base = int'($urandom_range(4095, 300));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(39) == 0) base = int'($urandom_range(4095, 300));
            else if ($urandom_range(3) == 0) base = base + int'($urandom_range(16)) - 8;
            send_rate(make_rate(base));
        end
    endtask

    task automatic test_directed_extremes();
        t_rate_req r;
        r = '{12'd1000, 13'd4096, 12'd990, 12'd1010, 6'd2, 14'd64};
        repeat (4) send_rate(r);
        send_rate('{12'd0, 13'd4096, 12'd0, 12'd0, 6'd0, 14'd0});
        send_rate('{12'd4095, 13'd8191, 12'd4095, 12'd0, 6'd63, 14'd1});
        send_rate('{12'd1000, 13'd0, 12'd0, 12'd4095, 6'd1, 14'd16383});
        send_rate('{12'd2000, 13'd4096, 12'd1500, 12'd1400, 6'd3, 14'd32});
        repeat (3) send_rate('{12'd1001, 13'd5000, 12'd1000, 12'd1002, 6'd2, 14'd64});
        repeat (12) send_rate('{12'd0, 13'd100, 12'd0, 12'd0, 6'd0, 14'd16383});
    endtask

    task automatic test_register_corners();
        write_reg(REG_SIGMA_MAX, 13'd0);
        write_reg(REG_SPAN_MAX, 13'd0);
        write_reg(REG_NONE_LO, 13'h1FFF);
        write_reg(REG_NONE_HI, 13'h0AAA);
        run_stream(10);
        write_reg(REG_MIN_CONS, 13'd0);
        write_reg(REG_ACCEPT_TH, 13'd0);
        send_rate('{12'd0, 13'd0, 12'd0, 12'd0, 6'd0, 14'd0});
        write_reg(REG_SIGMA_MAX, 13'h1FFF);
        write_reg(REG_SPAN_MAX, 13'h1FFF);
        write_reg(REG_MAX_HOLD, 13'h1FFF);
        write_reg(REG_ACCEPT_TH, 13'd4096);
        write_reg(REG_DEGRADE_TH, 13'd4096);
        write_reg(REG_MIN_CONS, 13'd4096);
        run_stream(20);
        write_reg(REG_MAX_HOLD, 13'd0);
        write_reg(REG_DEGRADE_TH, 13'd0);
        run_stream(15);
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_ACCEPT_TH, 13'($urandom_range(3500, 1000)));
            write_reg(REG_DEGRADE_TH, 13'($urandom_range(2000, 200)));
            write_reg(REG_MIN_CONS, 13'($urandom_range(3500, 500)));
            write_reg(REG_MAX_HOLD, 13'($urandom_range(30)));
            write_reg(REG_SIGMA_MAX, 13'($urandom_range(600, 40)));
            write_reg(REG_SPAN_MAX, 13'($urandom_range(800, 40)));
            quiet_mode = (ph == 2);
            run_stream(120);
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        write_reg(REG_ACCEPT_TH, RST_ACCEPT_TH);
        write_reg(REG_MAX_HOLD, 13'(RST_MAX_HOLD));
        hold_req_cnt++;
        run_stream(60);
        wait_drained();
        run_stream(60);
    endtask

    // result checker, receiver idling and stall watchdog
    always @(posedge i_clk) begin
        t_verdict got, exp_v;
        if (o_valid && i_ready) begin
            got = '{o_decision, o_reason, o_out_rate, o_out_valid, o_calibrated_confidence,
                    o_consistency, o_agreement, o_resolution_quality,
                    o_trusted_rate_out, o_trust_age_out};
            if (exp_wr == exp_rd) begin
                $display("%0t unexpected request result %p", $time, got);
                fail_cnt++;
            end else begin
                exp_v = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (got.decision !== exp_v.decision || got.reason !== exp_v.reason ||
                    got.out_rate !== exp_v.out_rate || got.out_valid !== exp_v.out_valid ||
                    got.calib !== exp_v.calib ||
                    got.consistency !== exp_v.consistency ||
                    got.agreement !== exp_v.agreement ||
                    got.res_quality !== exp_v.res_quality ||
                    got.trusted_rate !== exp_v.trusted_rate ||
                    got.age_out !== exp_v.age_out) begin
                    $display("%0t mismatch expected %p actual %p", $time, exp_v, got);
                    fail_cnt++;
                end
            end
        end
        if (hold_seen_cnt != hold_req_cnt) begin
            hold_seen_cnt = hold_req_cnt;
            hold_left = 700;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= quiet_mode || ($urandom_range(99) >= 21);
        end
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) stall_cnt = 0;
        else stall_cnt++;
        if (stall_cnt > STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        cfg_accept_th = RST_ACCEPT_TH;
        cfg_degrade_th = RST_DEGRADE_TH;
        cfg_min_cons = RST_MIN_CONS;
        cfg_max_hold = RST_MAX_HOLD;
        cfg_sigma_max = RST_SIGMA_MAX;
        cfg_span_max = RST_SPAN_MAX;
        hist_cnt = 0;
        hist_head = 0;
        trust_rate = '0;
        exp_age = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_register_corners();
        test_random_settings();
        test_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && exp_wr == exp_rd) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/rthm_pkg.sv
sv/rthm_unit.sv
sv/rate_trust_hold_machine.sv
tb/rate_trust_hold_machine_tb.sv
